/* rtl/wsmp_pkg.sv */
package wsmp_pkg;

   localparam int MaxFrameBytes = 4096;
   localparam int OffsetCapInt  = ((MaxFrameBytes - 1) < 4095) ? (MaxFrameBytes - 1) : 4095;

   localparam logic [11:0] OffsetCap     = 12'(OffsetCapInt);
   localparam logic [11:0] MacLastOffset = 12'd25;
   localparam logic [11:0] LlcLastOffset = 12'd27;

   localparam logic [7:0] VersionWithExt = 8'h0b;
   localparam logic [7:0] LengthOneMax   = 8'h7f;

   // parse phases, also used as region tags
   localparam logic [3:0] PhMac    = 4'd0;
   localparam logic [3:0] PhLlc    = 4'd1;
   localparam logic [3:0] PhVer    = 4'd2;
   localparam logic [3:0] PhExtCnt = 4'd3;
   localparam logic [3:0] PhExt    = 4'd4;
   localparam logic [3:0] PhTpid   = 4'd5;
   localparam logic [3:0] PhPsid   = 4'd6;
   localparam logic [3:0] PhLen    = 4'd7;
   localparam logic [3:0] PhPay    = 4'd8;

   // extension element steps
   localparam logic [1:0] ElemId   = 2'd0;
   localparam logic [1:0] ElemLen  = 2'd1;
   localparam logic [1:0] ElemBody = 2'd2;

   typedef struct packed {
      logic [7:0]  byte_out;
      logic [3:0]  region;
      logic [11:0] byte_offset;
      logic        header_done;
      logic [31:0] psid_raw;
      logic [2:0]  psid_bytes;
      logic [7:0]  tpid_value;
      logic [7:0]  extension_count;
      logic [15:0] length_raw;
      logic        frame_last;
      logic        truncated;
   } wsmp_result_type;

endpackage

/* rtl/wsmp_parse.sv */
module wsmp_parse
   import wsmp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      frame_byte,
   input  logic            frame_end,
   output wsmp_result_type result
);

   logic [3:0]  phase_ff,     phase_in;
   logic [11:0] pos_ff,       pos_in;
   logic [7:0]  ext_left_ff,  ext_left_in;
   logic [7:0]  elem_left_ff, elem_left_in;
   logic [1:0]  elem_step_ff, elem_step_in;
   logic [31:0] psid_acc_ff,  psid_acc_in;
   logic [2:0]  psid_rem_ff,  psid_rem_in;
   logic [2:0]  psid_seen_ff, psid_seen_in;
   logic [7:0]  tpid_ff,      tpid_in;
   logic [7:0]  ext_cnt_ff,   ext_cnt_in;
   logic [15:0] len_acc_ff,   len_acc_in;
   logic [1:0]  len_rem_ff,   len_rem_in;

   logic [3:0]  region;
   logic        done;
   logic        finish;
   logic [7:0]  ext_left_dec;
   logic [7:0]  elem_left_dec;
   logic [2:0]  psid_nbytes;

   assign ext_left_dec  = ext_left_ff - 8'd1;
   assign elem_left_dec = elem_left_ff - 8'd1;

   // psid length from the top nibble of its first byte
   always_comb begin
      case (frame_byte[7:4]) inside
         [4'd0:4'd7]:   psid_nbytes = 3'd1;
         [4'd8:4'd11]:  psid_nbytes = 3'd2;
         [4'd12:4'd13]: psid_nbytes = 3'd3;
         default:       psid_nbytes = 3'd4;
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      ext_left_in  = ext_left_ff;
      elem_left_in = elem_left_ff;
      elem_step_in = elem_step_ff;
      psid_acc_in  = psid_acc_ff;
      psid_rem_in  = psid_rem_ff;
      psid_seen_in = psid_seen_ff;
      tpid_in      = tpid_ff;
      ext_cnt_in   = ext_cnt_ff;
      len_acc_in   = len_acc_ff;
      len_rem_in   = len_rem_ff;
      region       = PhPay;
      done         = 1'b0;
      finish       = 1'b0;

      case (phase_ff)
         PhMac: begin
            region = PhMac;
            if (pos_ff >= MacLastOffset) phase_in = PhLlc;
         end
         PhLlc: begin
            region = PhLlc;
            if (pos_ff >= LlcLastOffset) phase_in = PhVer;
         end
         PhVer: begin
            region = PhVer;
            if (frame_byte == VersionWithExt) begin
               phase_in = PhExtCnt;
            end else begin
               ext_cnt_in = 8'd0;
               phase_in   = PhTpid;
            end
         end
         PhExtCnt: begin
            region       = PhExtCnt;
            ext_cnt_in   = frame_byte;
            ext_left_in  = frame_byte;
            elem_step_in = ElemId;
            phase_in     = (frame_byte != 8'd0) ? PhExt : PhTpid;
         end
         PhExt: begin
            region = PhExt;
            case (elem_step_ff)
               ElemId: begin
                  elem_step_in = ElemLen;
               end
               ElemLen: begin
                  elem_left_in = frame_byte;
                  if (frame_byte == 8'd0) finish = 1'b1;
                  else elem_step_in = ElemBody;
               end
               default: begin
                  elem_left_in = elem_left_dec;
                  if (elem_left_dec == 8'd0) finish = 1'b1;
               end
            endcase
            if (finish) begin
               elem_step_in = ElemId;
               elem_left_in = 8'd0;
               ext_left_in  = ext_left_dec;
               if (ext_left_dec == 8'd0) phase_in = PhTpid;
            end
         end
         PhTpid: begin
            region       = PhTpid;
            tpid_in      = frame_byte;
            psid_seen_in = 3'd0;
            phase_in     = PhPsid;
         end
         PhPsid: begin
            region = PhPsid;
            if (psid_seen_ff == 3'd0) begin
               psid_seen_in = psid_nbytes;
               psid_rem_in  = psid_nbytes - 3'd1;
               psid_acc_in  = {24'd0, frame_byte};
            end else begin
               psid_acc_in = {psid_acc_ff[23:0], frame_byte};
               psid_rem_in = psid_rem_ff - 3'd1;
            end
            if (psid_rem_in == 3'd0) begin
               len_rem_in = 2'd0;
               phase_in   = PhLen;
            end
         end
         PhLen: begin
            region = PhLen;
            if (len_rem_ff == 2'd0) begin
               len_acc_in = {8'd0, frame_byte};
               if (frame_byte > LengthOneMax) len_rem_in = 2'd1;
               else done = 1'b1;
            end else begin
               len_acc_in = {len_acc_ff[7:0], frame_byte};
               len_rem_in = 2'd0;
               done       = 1'b1;
            end
            if (done) phase_in = PhPay;
         end
         default: begin
            region   = PhPay;
            phase_in = PhPay;
         end
      endcase

      pos_in = (pos_ff < OffsetCap) ? (pos_ff + 12'd1) : pos_ff;

      // end of frame returns everything to the start of a new frame
      if (frame_end) begin
         phase_in     = PhMac;
         pos_in       = 12'd0;
         ext_left_in  = 8'd0;
         elem_left_in = 8'd0;
         elem_step_in = ElemId;
         psid_acc_in  = 32'd0;
         psid_rem_in  = 3'd0;
         psid_seen_in = 3'd0;
         tpid_in      = 8'd0;
         ext_cnt_in   = 8'd0;
         len_acc_in   = 16'd0;
         len_rem_in   = 2'd0;
      end
   end

   always_comb begin
      result.byte_out        = frame_byte;
      result.region          = region;
      result.byte_offset     = pos_ff;
      result.header_done     = done;
      result.psid_raw        = done ? psid_acc_ff : 32'd0;
      result.psid_bytes      = done ? psid_seen_ff : 3'd0;
      result.tpid_value      = done ? tpid_ff : 8'd0;
      result.extension_count = done ? ext_cnt_ff : 8'd0;
      // length bytes as received, independent of the end of frame clear
      result.length_raw      = done ? {((len_rem_ff == 2'd0) ? 8'd0 : len_acc_ff[7:0]),
                                       frame_byte} : 16'd0;
      result.frame_last      = frame_end;
      result.truncated       = frame_end & ~done & (phase_ff != PhPay);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PhMac;
         pos_ff       <= 12'd0;
         ext_left_ff  <= 8'd0;
         elem_left_ff <= 8'd0;
         elem_step_ff <= ElemId;
         psid_acc_ff  <= 32'd0;
         psid_rem_ff  <= 3'd0;
         psid_seen_ff <= 3'd0;
         tpid_ff      <= 8'd0;
         ext_cnt_ff   <= 8'd0;
         len_acc_ff   <= 16'd0;
         len_rem_ff   <= 2'd0;
      end else if (step) begin
         phase_ff     <= phase_in;
         pos_ff       <= pos_in;
         ext_left_ff  <= ext_left_in;
         elem_left_ff <= elem_left_in;
         elem_step_ff <= elem_step_in;
         psid_acc_ff  <= psid_acc_in;
         psid_rem_ff  <= psid_rem_in;
         psid_seen_ff <= psid_seen_in;
         tpid_ff      <= tpid_in;
         ext_cnt_ff   <= ext_cnt_in;
         len_acc_ff   <= len_acc_in;
         len_rem_ff   <= len_rem_in;
      end
   end

endmodule

/* rtl/wsmp_header_parser.sv */
// WSMP header parser. Frame bytes enter one per transfer on the req_ channel, starting
// with the first byte of the 802.11 QoS header, and each byte leaves on the rsp_ channel
// with its region tag and frame offset. The byte that completes the WSM length field
// carries header_done with the PSID, PSID length, TPID, extension count and raw length;
// a frame that ends before that point is flagged truncated on its last byte. A byte
// goes through an input register and a result register before its result is
// presented on rsp_. One byte per cycle is sustained while rsp_ready stays high, since
// the parse state is updated as each byte moves from the input register to the result
// register; a stalled result holds the input register, and req_ready then falls.
module wsmp_header_parser
   import wsmp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_frame_byte,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_byte_out,
   output logic [3:0]  rsp_region,
   output logic [11:0] rsp_byte_offset,
   output logic        rsp_header_done,
   output logic [31:0] rsp_psid_raw,
   output logic [2:0]  rsp_psid_bytes,
   output logic [7:0]  rsp_tpid_value,
   output logic [7:0]  rsp_extension_count,
   output logic [15:0] rsp_length_raw,
   output logic        rsp_frame_last,
   output logic        rsp_truncated
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic            in_end_ff;
   logic            out_valid_ff, out_valid_in;
   wsmp_result_type out_ff;
   wsmp_result_type result;
   logic            out_free;
   logic            advance;
   logic            req_xfer;

   assign out_free  = ~out_valid_ff | rsp_ready;
   assign advance   = in_valid_ff & out_free;
   assign req_ready = ~in_valid_ff | out_free;
   assign req_xfer  = req_valid & req_ready;

   assign in_valid_in  = req_xfer | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_ready);

   wsmp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .frame_byte (in_byte_ff),
      .frame_end  (in_end_ff),
      .result     (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_byte_ff <= req_frame_byte;
         in_end_ff  <= req_frame_end;
      end
      if (advance) out_ff <= result;
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_byte_out        = out_ff.byte_out;
   assign rsp_region          = out_ff.region;
   assign rsp_byte_offset     = out_ff.byte_offset;
   assign rsp_header_done     = out_ff.header_done;
   assign rsp_psid_raw        = out_ff.psid_raw;
   assign rsp_psid_bytes      = out_ff.psid_bytes;
   assign rsp_tpid_value      = out_ff.tpid_value;
   assign rsp_extension_count = out_ff.extension_count;
   assign rsp_length_raw      = out_ff.length_raw;
   assign rsp_frame_last      = out_ff.frame_last;
   assign rsp_truncated       = out_ff.truncated;

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb
   import wsmp_pkg::*;
();

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } frame_byte_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_frame_byte = 8'h00;
   logic        req_frame_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_byte_out;
   logic [3:0]  rsp_region;
   logic [11:0] rsp_byte_offset;
   logic        rsp_header_done;
   logic [31:0] rsp_psid_raw;
   logic [2:0]  rsp_psid_bytes;
   logic [7:0]  rsp_tpid_value;
   logic [7:0]  rsp_extension_count;
   logic [15:0] rsp_length_raw;
   logic        rsp_frame_last;
   logic        rsp_truncated;

   wsmp_header_parser dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_frame_byte      (req_frame_byte),
      .req_frame_end       (req_frame_end),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_byte_out        (rsp_byte_out),
      .rsp_region          (rsp_region),
      .rsp_byte_offset     (rsp_byte_offset),
      .rsp_header_done     (rsp_header_done),
      .rsp_psid_raw        (rsp_psid_raw),
      .rsp_psid_bytes      (rsp_psid_bytes),
      .rsp_tpid_value      (rsp_tpid_value),
      .rsp_extension_count (rsp_extension_count),
      .rsp_length_raw      (rsp_length_raw),
      .rsp_frame_last      (rsp_frame_last),
      .rsp_truncated       (rsp_truncated)
   );

   frame_byte_type  tx_bytes[$];
   frame_byte_type  next_byte;
   wsmp_result_type expected_echoes[$];
   wsmp_result_type predicted;
   wsmp_result_type wanted;
   wsmp_result_type observed;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int error_count = 0;
   int bytes_queued = 0;
   int frames_queued = 0;
   int headers_seen = 0;
   int truncations_seen = 0;
   int saturated_seen = 0;

   // parser state mirror
   logic [3:0]  walk_phase = PhMac;
   logic [11:0] walk_pos = '0;
   logic [7:0]  ext_left = '0;
   logic [7:0]  elem_left = '0;
   logic [1:0]  elem_step = ElemId;
   logic [31:0] psid_acc = '0;
   logic [2:0]  psid_left = '0;
   logic [2:0]  psid_count = '0;
   logic [7:0]  tpid_seen = '0;
   logic [7:0]  ext_count_seen = '0;
   logic [15:0] len_acc = '0;
   logic [1:0]  len_left = '0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      #4000000;
      $display("timeout with %0d results outstanding", expected_echoes.size());
      $display("FAIL wsmp_header_parser");
      $finish;
   end

   task automatic clear_parse();
      walk_phase = PhMac;
      walk_pos = '0;
      ext_left = '0;
      elem_left = '0;
      elem_step = ElemId;
      psid_acc = '0;
      psid_left = '0;
      psid_count = '0;
      tpid_seen = '0;
      ext_count_seen = '0;
      len_acc = '0;
      len_left = '0;
   endtask

   task automatic parse_byte(input logic [7:0] b, input logic fe, output wsmp_result_type r);
      logic done;
      logic in_payload;
      logic elem_closed;
      logic [2:0] n;
      done = 1'b0;
      elem_closed = 1'b0;
      in_payload = (walk_phase == PhPay);
      r = '0;
      r.byte_out = b;
      r.region = walk_phase;
      r.byte_offset = walk_pos;
      case (walk_phase)
         PhMac: begin
            if (walk_pos >= MacLastOffset) walk_phase = PhLlc;
         end
         PhLlc: begin
            if (walk_pos >= LlcLastOffset) walk_phase = PhVer;
         end
         PhVer: begin
            if (b == VersionWithExt) begin
               walk_phase = PhExtCnt;
            end else begin
               ext_count_seen = '0;
               walk_phase = PhTpid;
            end
         end
         PhExtCnt: begin
            ext_count_seen = b;
            ext_left = b;
            elem_step = ElemId;
            walk_phase = (b != 0) ? PhExt : PhTpid;
         end
         PhExt: begin
            if (elem_step == ElemId) begin
               elem_step = ElemLen;
            end else if (elem_step == ElemLen) begin
               elem_left = b;
               if (b == 0) elem_closed = 1'b1;
               else elem_step = ElemBody;
            end else begin
               elem_left = elem_left - 8'd1;
               if (elem_left == 0) elem_closed = 1'b1;
            end
            if (elem_closed) begin
               elem_step = ElemId;
               elem_left = '0;
               ext_left = ext_left - 8'd1;
               if (ext_left == 0) walk_phase = PhTpid;
            end
         end
         PhTpid: begin
            tpid_seen = b;
            psid_count = '0;
            walk_phase = PhPsid;
         end
         PhPsid: begin
            if (psid_count == 0) begin
               if (!b[7]) n = 3'd1;
               else if (!b[6]) n = 3'd2;
               else if (!b[5]) n = 3'd3;
               else n = 3'd4;
               psid_count = n;
               psid_left = n - 3'd1;
               psid_acc = {24'h0, b};
            end else begin
               psid_acc = {psid_acc[23:0], b};
               psid_left = psid_left - 3'd1;
            end
            if (psid_left == 0) begin
               len_left = '0;
               walk_phase = PhLen;
            end
         end
         PhLen: begin
            if (len_left == 0) begin
               len_acc = {8'h00, b};
               if (b > LengthOneMax) len_left = 2'd1;
               else done = 1'b1;
            end else begin
               len_acc = {len_acc[7:0], b};
               len_left = '0;
               done = 1'b1;
            end
            if (done) walk_phase = PhPay;
         end
         default: begin
            walk_phase = PhPay;
         end
      endcase
      r.header_done = done;
      if (done) begin
         r.psid_raw = psid_acc;
         r.psid_bytes = psid_count;
         r.tpid_value = tpid_seen;
         r.extension_count = ext_count_seen;
         r.length_raw = len_acc;
      end
      r.frame_last = fe;
      r.truncated = fe && !done && !in_payload;
      if (walk_pos < OffsetCap) walk_pos = walk_pos + 12'd1;
      if (fe) clear_parse();
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $display("%0t mismatch %s expected %0h actual %0h", $time, name, want, got);
         error_count++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (tx_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_byte = tx_bytes.pop_front();
            req_valid <= 1'b1;
            req_frame_byte <= next_byte.data;
            req_frame_end <= next_byte.last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         clear_parse();
      end else begin
         if (req_valid && req_ready) begin
            parse_byte(req_frame_byte, req_frame_end, predicted);
            expected_echoes.push_back(predicted);
            if (predicted.header_done) headers_seen++;
            if (predicted.truncated) truncations_seen++;
            if (predicted.byte_offset == OffsetCap) saturated_seen++;
         end
         if (rsp_valid && rsp_ready) begin
            observed = {rsp_byte_out, rsp_region, rsp_byte_offset, rsp_header_done,
                        rsp_psid_raw, rsp_psid_bytes, rsp_tpid_value, rsp_extension_count,
                        rsp_length_raw, rsp_frame_last, rsp_truncated};
            if (expected_echoes.size() == 0) begin
               $display("%0t unexpected transfer byte %0h with nothing expected",
                        $time, rsp_byte_out);
               error_count++;
            end else begin
               wanted = expected_echoes.pop_front();
               check_field("byte_out", 32'(wanted.byte_out), 32'(observed.byte_out));
               check_field("region", 32'(wanted.region), 32'(observed.region));
               check_field("byte_offset", 32'(wanted.byte_offset),
                           32'(observed.byte_offset));
               check_field("header_done", 32'(wanted.header_done),
                           32'(observed.header_done));
               check_field("psid_raw", wanted.psid_raw, observed.psid_raw);
               check_field("psid_bytes", 32'(wanted.psid_bytes), 32'(observed.psid_bytes));
               check_field("tpid_value", 32'(wanted.tpid_value), 32'(observed.tpid_value));
               check_field("extension_count", 32'(wanted.extension_count),
                           32'(observed.extension_count));
               check_field("length_raw", 32'(wanted.length_raw), 32'(observed.length_raw));
               check_field("frame_last", 32'(wanted.frame_last), 32'(observed.frame_last));
               check_field("truncated", 32'(wanted.truncated), 32'(observed.truncated));
            end
         end
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic fe);
      tx_bytes.push_back('{data: b, last: fe});
      bytes_queued++;
      if (fe) frames_queued++;
   endtask

   // cut = 0 or cut not below the frame size sends the whole frame, otherwise only the first cut bytes
   task automatic build_frame(input logic [7:0] version, input int ext_n, input int elem_max,
                              input logic [7:0] psid0, input logic [7:0] len0,
                              input int pay_n, input int cut);
      logic [7:0] fb[$];
      int el;
      int n_ps;
      int last;
      for (int i = 0; i < 28; i++) fb.push_back(8'($urandom));
      fb.push_back(version);
      if (version == VersionWithExt) begin
         fb.push_back(8'(ext_n));
         for (int e = 0; e < ext_n; e++) begin
            el = $urandom_range(elem_max, 0);
            fb.push_back(8'($urandom));
            fb.push_back(8'(el));
            for (int k = 0; k < el; k++) fb.push_back(8'($urandom));
         end
      end
      fb.push_back(8'($urandom));
      fb.push_back(psid0);
      n_ps = !psid0[7] ? 1 : !psid0[6] ? 2 : !psid0[5] ? 3 : 4;
      for (int k = 1; k < n_ps; k++) fb.push_back(8'($urandom));
      fb.push_back(len0);
      if (len0 > LengthOneMax) fb.push_back(8'($urandom));
      for (int k = 0; k < pay_n; k++) fb.push_back(8'($urandom));
      last = (cut > 0 && cut < fb.size()) ? cut : fb.size();
      for (int i = 0; i < last; i++) push_byte(fb[i], i == last - 1);
   endtask

   task automatic push_random_frame();
      int pick;
      int len;
      logic [7:0] version;
      int ext_n;
      int elem_max;
      pick = $urandom_range(99);
      if (pick < 8) begin
         len = $urandom_range(60, 1);
         for (int i = 0; i < len; i++) push_byte(8'($urandom), i == len - 1);
      end else begin
         version = ($urandom_range(3) != 0) ? VersionWithExt : 8'($urandom);
         ext_n = ($urandom_range(99) < 3) ? $urandom_range(255) : $urandom_range(3);
         elem_max = (ext_n > 3) ? 2 : ($urandom_range(9) == 0) ? 255 : 4;
         build_frame(version, ext_n, elem_max, 8'($urandom), 8'($urandom),
                     $urandom_range(16), ($urandom_range(99) < 15) ? $urandom_range(45, 1) : 0);
      end
   endtask

   initial begin
      int phase_start;
      while (reset) @(posedge clock);

      push_byte(8'hff, 1'b1);
      build_frame(8'h00, 0, 0, 8'h20, 8'h05, 3, 0);
      build_frame(VersionWithExt, 0, 0, 8'h80, 8'h80, 2, 0);
      build_frame(VersionWithExt, 2, 0, 8'hc0, 8'h7f, 0, 0);
      build_frame(VersionWithExt, 3, 3, 8'hff, 8'hff, 1, 0);
      build_frame(8'h0a, 0, 0, 8'hbf, 8'h00, 1, 0);
      build_frame(8'h0c, 0, 0, 8'hdf, 8'h81, 1, 0);
      build_frame(8'hff, 0, 0, 8'he0, 8'h7f, 2, 0);
      build_frame(8'h00, 0, 0, 8'h7f, 8'h01, 1, 0);
      build_frame(VersionWithExt, 2, 5, 8'h10, 8'h10, 1, 33);
      build_frame(8'h00, 0, 0, 8'hf0, 8'h10, 1, 32);
      build_frame(8'h00, 0, 0, 8'h00, 8'h90, 4, 32);
      build_frame(VersionWithExt, 255, 0, 8'h41, 8'h22, 2, 0);
      for (int i = 0; i < 40; i++) push_byte(8'hff, i == 39);
      for (int i = 0; i < 40; i++) push_byte(8'h00, i == 39);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 26; recv_stall_pct = 26; end
         endcase
         phase_start = bytes_queued;
         while (bytes_queued - phase_start < 160) push_random_frame();
         // sender holds off until every result is back
         while (tx_bytes.size() != 0 || req_valid || expected_echoes.size() != 0)
            @(posedge clock);
      end

      repeat (10) @(posedge clock);
      $display("run covered %0d bytes in %0d frames: %0d headers completed, %0d truncated",
               bytes_queued, frames_queued, headers_seen, truncations_seen);
      $display("idle mixes none, sender, receiver and both; %0d bytes at saturated offset",
               saturated_seen);
      if (error_count == 0) begin
         $display("PASS wsmp_header_parser");
      end else begin
         $display("FAIL wsmp_header_parser");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/wsmp_pkg.sv
rtl/wsmp_parse.sv
rtl/wsmp_header_parser.sv
tb/sv/tb.sv
